// ----- rtl/hpt_pkg.sv -----
// Shared constants, types and arithmetic helpers for the homogeneous point transform.
package hpt_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int COEF_WIDTH_DEF  = 16;
    localparam int ACC_WIDTH       = 64;
    localparam int COORD_FRAC      = 16;
    localparam int COEF_FRAC       = 8;
    localparam int SLOT_WIDTH      = 16;
    localparam int ROW_WIDTH       = 64;
    localparam int WMIN_WIDTH      = 16;
    localparam int CFG_IDX_WIDTH   = 3;

    localparam logic [CFG_IDX_WIDTH-1:0] REG_ROW0 = 3'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_ROW1 = 3'd1;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_ROW2 = 3'd2;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_ROW3 = 3'd3;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_WMIN = 3'd4;

    localparam logic [ROW_WIDTH-1:0]  ROW0_RESET = 64'h0000_0000_0000_0100;
    localparam logic [ROW_WIDTH-1:0]  ROW1_RESET = 64'h0000_0000_0100_0000;
    localparam logic [ROW_WIDTH-1:0]  ROW2_RESET = 64'h0000_0100_0000_0000;
    localparam logic [ROW_WIDTH-1:0]  ROW3_RESET = 64'h0100_0000_0000_0000;
    localparam logic [WMIN_WIDTH-1:0] WMIN_RESET = 16'd16;

    localparam int MAC_LATENCY = 4;

    typedef logic signed [ACC_WIDTH-1:0] acc_t;
    typedef logic [3:0][ROW_WIDTH-1:0] rows_t;

    localparam acc_t ACC_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
    localparam acc_t ACC_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};

    function automatic acc_t sat_add(input acc_t a, input acc_t b);
        acc_t sum;
        logic ovf;
        sum = a + b;
        ovf = (a[ACC_WIDTH-1] == b[ACC_WIDTH-1]) && (sum[ACC_WIDTH-1] != a[ACC_WIDTH-1]);
        if (ovf)
        begin
            sum = a[ACC_WIDTH-1] ? ACC_MIN : ACC_MAX;
        end
        return sum;
    endfunction

endpackage

// ----- rtl/hpt_mac.sv -----
// Matrix multiply-accumulate pipeline: products, then three saturating accumulate stages.
module hpt_mac #(
    parameter int COORD_WIDTH = hpt_pkg::COORD_WIDTH_DEF,
    parameter int COEF_WIDTH  = hpt_pkg::COEF_WIDTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        vld_i,
    input  logic                        vec_i,
    input  logic [2:0][COORD_WIDTH-1:0] coord_i,
    input  hpt_pkg::rows_t              rows,
    output logic                        vld_o,
    output logic                        vec_o,
    output hpt_pkg::acc_t               acc_o [4]
);
    import hpt_pkg::*;

    acc_t p1_reg [4][3];
    acc_t p1_next [4][3];
    acc_t t1_reg [4];
    acc_t t1_next [4];
    logic vec1_reg;
    logic vld1_reg;

    acc_t s2_reg [4];
    acc_t p2_reg [4];
    acc_t t2_reg [4];
    logic vec2_reg;
    logic vld2_reg;

    acc_t s3_reg [4];
    acc_t t3_reg [4];
    logic vec3_reg;
    logic vld3_reg;

    acc_t acc4_reg [4];
    acc_t acc4_next [4];
    logic vec4_reg;
    logic vld4_reg;

    always_comb
    begin
        logic signed [COEF_WIDTH-1:0] cf;
        logic signed [COEF_WIDTH+COORD_WIDTH-1:0] prod;
        for (int r = 0; r < 4; r++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                cf = rows[r][SLOT_WIDTH*k +: COEF_WIDTH];
                prod = $signed(cf) * $signed(coord_i[k]);
                p1_next[r][k] = acc_t'(prod);
            end
            cf = rows[r][SLOT_WIDTH*3 +: COEF_WIDTH];
            t1_next[r] = acc_t'(cf) <<< COORD_FRAC;
        end
    end

    always_comb
    begin
        for (int r = 0; r < 4; r++)
        begin
            acc4_next[r] = sat_add(s3_reg[r], t3_reg[r]);
            if (vec3_reg && r < 3)
            begin
                acc4_next[r] = s3_reg[r];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
            vld3_reg <= 1'b0;
            vld4_reg <= 1'b0;
        end
        else if (en)
        begin
            vld1_reg <= vld_i;
            vld2_reg <= vld1_reg;
            vld3_reg <= vld2_reg;
            vld4_reg <= vld3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_reg   <= p1_next;
            t1_reg   <= t1_next;
            vec1_reg <= vec_i;
            vec2_reg <= vec1_reg;
            vec3_reg <= vec2_reg;
            vec4_reg <= vec3_reg;
            for (int r = 0; r < 4; r++)
            begin
                s2_reg[r] <= sat_add(p1_reg[r][0], p1_reg[r][1]);
                p2_reg[r] <= p1_reg[r][2];
                t2_reg[r] <= t1_reg[r];
                s3_reg[r] <= sat_add(s2_reg[r], p2_reg[r]);
                t3_reg[r] <= t2_reg[r];
            end
            acc4_reg <= acc4_next;
        end
    end

    assign vld_o = vld4_reg;
    assign vec_o = vec4_reg;
    assign acc_o = acc4_reg;

endmodule

// ----- rtl/hpt_lane.sv -----
// One output component: shrink path and a one-bit-per-stage pipelined divide by w.
module hpt_lane #(
    parameter int COORD_WIDTH = hpt_pkg::COORD_WIDTH_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic                   vld_i,
    input  logic                   dv_i,
    input  hpt_pkg::acc_t          acc_i,
    input  hpt_pkg::acc_t          w_i,
    output logic                   vld_o,
    output logic                   dv_o,
    output logic [COORD_WIDTH-1:0] val_o,
    output logic                   sat_o
);
    import hpt_pkg::*;

    localparam int NW = ACC_WIDTH + COORD_WIDTH;
    localparam acc_t MAXV = (acc_t'(1) <<< (COORD_WIDTH - 1)) - acc_t'(1);
    localparam acc_t MINV = -MAXV - acc_t'(1);
    localparam logic [COORD_WIDTH-1:0] HALF = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    typedef struct packed {
        logic                   neg;
        logic                   over;
        logic                   dv;
        logic                   ss;
        logic [COORD_WIDTH-1:0] sv;
    } side_t;

    logic [ACC_WIDTH-1:0] n5_reg;
    logic [ACC_WIDTH-1:0] d5_reg;
    side_t                side5_reg;
    side_t                side5_next;
    side_t                side0_next;
    logic                 vld5_reg;

    logic [ACC_WIDTH-1:0]   rem_reg  [COORD_WIDTH+1];
    logic [COORD_WIDTH-1:0] quo_reg  [COORD_WIDTH+1];
    logic [ACC_WIDTH-1:0]   dd_reg   [COORD_WIDTH+1];
    side_t                  side_reg [COORD_WIDTH+1];
    logic                   vld_reg  [COORD_WIDTH+1];

    logic [NW-1:0] num_full;
    logic [NW-1:0] den_full;

    logic [COORD_WIDTH-1:0] lim;
    logic [COORD_WIDTH-1:0] mag;
    logic [COORD_WIDTH-1:0] dval;
    logic                   dsat;

    logic [COORD_WIDTH-1:0] val_reg;
    logic                   sat_reg;
    logic                   dv_reg;
    logic                   vldo_reg;

    always_comb
    begin
        acc_t f;
        f = acc_i >>> COEF_FRAC;
        side5_next.neg  = acc_i[ACC_WIDTH-1] ^ w_i[ACC_WIDTH-1];
        side5_next.over = 1'b0;
        side5_next.dv   = dv_i;
        if (f > MAXV)
        begin
            side5_next.sv = MAXV[COORD_WIDTH-1:0];
            side5_next.ss = 1'b1;
        end
        else if (f < MINV)
        begin
            side5_next.sv = MINV[COORD_WIDTH-1:0];
            side5_next.ss = 1'b1;
        end
        else
        begin
            side5_next.sv = f[COORD_WIDTH-1:0];
            side5_next.ss = 1'b0;
        end
    end

    assign num_full = NW'({n5_reg, {COORD_FRAC{1'b0}}});
    assign den_full = {d5_reg, {COORD_WIDTH{1'b0}}};

    always_comb
    begin
        side0_next      = side5_reg;
        side0_next.over = num_full >= den_full;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld5_reg   <= 1'b0;
            vld_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            vld5_reg   <= vld_i;
            vld_reg[0] <= vld5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n5_reg    <= acc_i[ACC_WIDTH-1] ? ACC_WIDTH'(-acc_i) : ACC_WIDTH'(acc_i);
            d5_reg    <= w_i[ACC_WIDTH-1] ? ACC_WIDTH'(-w_i) : ACC_WIDTH'(w_i);
            side5_reg <= side5_next;

            rem_reg[0]  <= num_full[NW-1:COORD_WIDTH];
            quo_reg[0]  <= num_full[COORD_WIDTH-1:0];
            dd_reg[0]   <= d5_reg;
            side_reg[0] <= side0_next;
        end
    end

    for (genvar i = 0; i < COORD_WIDTH; i++)
    begin : g_step
        logic [ACC_WIDTH:0] trial;
        logic [ACC_WIDTH:0] rem_next;
        logic               qbit;

        always_comb
        begin
            trial = {rem_reg[i], quo_reg[i][COORD_WIDTH-1]};
            if (trial >= {1'b0, dd_reg[i]})
            begin
                rem_next = trial - {1'b0, dd_reg[i]};
                qbit     = 1'b1;
            end
            else
            begin
                rem_next = trial;
                qbit     = 1'b0;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[i+1] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[i+1] <= vld_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i+1]  <= rem_next[ACC_WIDTH-1:0];
                quo_reg[i+1]  <= {quo_reg[i][COORD_WIDTH-2:0], qbit};
                dd_reg[i+1]   <= dd_reg[i];
                side_reg[i+1] <= side_reg[i];
            end
        end
    end

    always_comb
    begin
        lim  = side_reg[COORD_WIDTH].neg ? HALF : HALF - 1'b1;
        dsat = side_reg[COORD_WIDTH].over || (quo_reg[COORD_WIDTH] > lim);
        mag  = dsat ? lim : quo_reg[COORD_WIDTH];
        dval = side_reg[COORD_WIDTH].neg ? (~mag + 1'b1) : mag;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vldo_reg <= 1'b0;
        end
        else if (en)
        begin
            vldo_reg <= vld_reg[COORD_WIDTH];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dv_reg  <= side_reg[COORD_WIDTH].dv;
            val_reg <= side_reg[COORD_WIDTH].dv ? dval : side_reg[COORD_WIDTH].sv;
            sat_reg <= side_reg[COORD_WIDTH].dv ? dsat : side_reg[COORD_WIDTH].ss;
        end
    end

    assign vld_o = vldo_reg;
    assign dv_o  = dv_reg;
    assign val_o = val_reg;
    assign sat_o = sat_reg;

    a_divisor_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        vld5_reg && side5_reg.dv |-> d5_reg != '0)
        else $error("divide selected with a zero divisor");

    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[0] && side_reg[0].dv && !side_reg[0].over |-> rem_reg[0] < dd_reg[0])
        else $error("initial remainder not below divisor without overflow");

endmodule

// ----- rtl/homogeneous_point_transform_core.sv -----
// Top level of the homogeneous 4x4 point transform with perspective divide.
// Input words (func, in_x, in_y, in_z) are taken on in_valid when in_stall is
// low; result words (out_x, out_y, out_z, divided, saturated) are offered on
// out_valid and taken when out_stall is low. One result is produced per word.
// Configuration is a plain write port: cfg_wen, cfg_index and cfg_wdata; rows
// 0 to 3 hold four signed Q8.8 coefficients each, index 4 holds the w
// threshold. Writes to other indices are ignored.
// A result passes through the multiply and accumulate stages, the divide set-up
// registers, the divide pipeline that resolves the quotient bit by bit, then the
// output register. A word can enter every cycle while in_stall is low.
// The whole pipeline advances together; while a result waits under
// out_stall, in_stall is raised and every stage holds, so nothing is lost or
// repeated. Reset clears all valid bits and loads the identity matrix and a
// threshold of 16.
module homogeneous_point_transform_core #(
    parameter int COORD_WIDTH = hpt_pkg::COORD_WIDTH_DEF,
    parameter int COEF_WIDTH  = hpt_pkg::COEF_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                func,
    input  logic signed [COORD_WIDTH-1:0]       in_x,
    input  logic signed [COORD_WIDTH-1:0]       in_y,
    input  logic signed [COORD_WIDTH-1:0]       in_z,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [COORD_WIDTH-1:0]       out_x,
    output logic signed [COORD_WIDTH-1:0]       out_y,
    output logic signed [COORD_WIDTH-1:0]       out_z,
    output logic                                divided,
    output logic                                saturated,
    input  logic                                cfg_wen,
    input  logic [hpt_pkg::CFG_IDX_WIDTH-1:0]   cfg_index,
    input  logic [hpt_pkg::ROW_WIDTH-1:0]       cfg_wdata
);
    import hpt_pkg::*;

    rows_t                 rows_reg;
    logic [WMIN_WIDTH-1:0] wmin_reg;

    logic                  en;
    logic                  mac_vld;
    logic                  mac_vec;
    acc_t                  mac_acc [4];
    logic [ACC_WIDTH-1:0]  w_mag;
    logic                  dv;

    logic [2:0][COORD_WIDTH-1:0] val;
    logic [2:0]                  sat;
    logic [2:0]                  lane_vld;
    logic [2:0]                  lane_dv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg[0] <= ROW0_RESET;
            rows_reg[1] <= ROW1_RESET;
            rows_reg[2] <= ROW2_RESET;
            rows_reg[3] <= ROW3_RESET;
            wmin_reg    <= WMIN_RESET;
        end
        else if (cfg_wen)
        begin
            unique case (cfg_index)
                REG_ROW0: rows_reg[0] <= cfg_wdata;
                REG_ROW1: rows_reg[1] <= cfg_wdata;
                REG_ROW2: rows_reg[2] <= cfg_wdata;
                REG_ROW3: rows_reg[3] <= cfg_wdata;
                REG_WMIN: wmin_reg    <= cfg_wdata[WMIN_WIDTH-1:0];
                default:  ;
            endcase
        end
    end

    assign en       = !(out_valid && out_stall);
    assign in_stall = !en;

    hpt_mac #(
        .COORD_WIDTH (COORD_WIDTH),
        .COEF_WIDTH  (COEF_WIDTH)
    ) u_mac (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .vld_i   (in_valid && !in_stall),
        .vec_i   (func),
        .coord_i ({in_z, in_y, in_x}),
        .rows    (rows_reg),
        .vld_o   (mac_vld),
        .vec_o   (mac_vec),
        .acc_o   (mac_acc)
    );

    assign w_mag = mac_acc[3][ACC_WIDTH-1] ? ACC_WIDTH'(-mac_acc[3]) : ACC_WIDTH'(mac_acc[3]);
    assign dv    = !mac_vec && (w_mag > ACC_WIDTH'(wmin_reg));

    for (genvar c = 0; c < 3; c++)
    begin : g_lane
        hpt_lane #(
            .COORD_WIDTH (COORD_WIDTH)
        ) u_lane (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (en),
            .vld_i (mac_vld),
            .dv_i  (dv),
            .acc_i (mac_acc[c]),
            .w_i   (mac_acc[3]),
            .vld_o (lane_vld[c]),
            .dv_o  (lane_dv[c]),
            .val_o (val[c]),
            .sat_o (sat[c])
        );
    end

    assign out_valid = lane_vld[0];
    assign divided   = lane_dv[0];
    assign out_x     = val[0];
    assign out_y     = val[1];
    assign out_z     = val[2];
    assign saturated = |sat;

    a_lanes_in_step: assert property (@(posedge clk) disable iff (!rst_n)
        lane_vld[0] == lane_vld[1] && lane_vld[0] == lane_vld[2])
        else $error("component lanes out of step");

    a_divide_flags_agree: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> lane_dv[0] == lane_dv[1] && lane_dv[0] == lane_dv[2])
        else $error("component lanes disagree on divide");

    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result lost while stalled");

endmodule

// ----- bench/hpt_checker.sv -----
// Checker for the homogeneous point transform: predicts each result word and compares it.
module hpt_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic                              in_stall,
    input  logic                              func,
    input  logic signed [31:0]                in_x,
    input  logic signed [31:0]                in_y,
    input  logic signed [31:0]                in_z,
    input  logic                              out_valid,
    input  logic                              out_stall,
    input  logic signed [31:0]                out_x,
    input  logic signed [31:0]                out_y,
    input  logic signed [31:0]                out_z,
    input  logic                              divided,
    input  logic                              saturated,
    input  logic                              cfg_wen,
    input  logic [hpt_pkg::CFG_IDX_WIDTH-1:0] cfg_index,
    input  logic [hpt_pkg::ROW_WIDTH-1:0]     cfg_wdata,
    output int                                fail_count,
    output int                                pending
);
    import hpt_pkg::*;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic               div;
        logic               sat;
    } point_t;

    logic [ROW_WIDTH-1:0]  matrix_rows [4];
    logic [WMIN_WIDTH-1:0] w_threshold;
    point_t                expected_points [$];

    assign pending = expected_points.size();

    function automatic logic signed [63:0] coef_at(input int r, input int c);
        logic signed [15:0] s;
        s = matrix_rows[r][16*c +: 16];
        return 64'(s);
    endfunction

    function automatic logic [63:0] mag_of(input logic signed [63:0] v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    function automatic logic signed [31:0] clamp_coord(input logic neg, input logic [63:0] mag,
                                                       input logic over, inout logic sat);
        logic [63:0] lim;
        lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
        if (over || mag > lim)
        begin
            mag = lim;
            sat = 1'b1;
        end
        return neg ? 32'(-mag) : 32'(mag);
    endfunction

    function automatic logic signed [31:0] scale_down(input logic signed [63:0] v, inout logic sat);
        logic signed [63:0] f;
        f = v >>> COEF_FRAC;
        return clamp_coord(f < 0, mag_of(f), 1'b0, sat);
    endfunction

    function automatic logic signed [31:0] perspective_divide(input logic signed [63:0] num,
                                                              input logic signed [63:0] den,
                                                              inout logic sat);
        logic [63:0] n;
        logic [63:0] d;
        logic [63:0] q;
        logic [63:0] r;
        logic        over;
        n = mag_of(num);
        d = mag_of(den);
        q = n / d;
        r = n % d;
        over = 1'b0;
        for (int i = 0; i < COORD_FRAC; i++)
        begin
            if (q > 64'h8000_0000)
                over = 1'b1;
            q = over ? 64'd0 : q << 1;
            r = r << 1;
            if (r >= d)
            begin
                r = r - d;
                q = q | 64'd1;
            end
        end
        return clamp_coord((num < 0) != (den < 0), q, over, sat);
    endfunction

    function automatic point_t transform_point(input logic vec, input logic signed [31:0] px,
                                               input logic signed [31:0] py,
                                               input logic signed [31:0] pz);
        logic signed [63:0] c [3];
        logic signed [63:0] acc [4];
        logic               sat;
        logic               div;
        point_t             p;
        c[0] = 64'(px);
        c[1] = 64'(py);
        c[2] = 64'(pz);
        for (int r = 0; r < 4; r++)
        begin
            acc[r] = 0;
            for (int k = 0; k < 3; k++)
                acc[r] = sat_add(acc[r], coef_at(r, k) * c[k]);
            if (!vec)
                acc[r] = sat_add(acc[r], coef_at(r, 3) <<< COORD_FRAC);
        end
        sat = 1'b0;
        div = !vec && (mag_of(acc[3]) > 64'(w_threshold));
        p.x = div ? perspective_divide(acc[0], acc[3], sat) : scale_down(acc[0], sat);
        p.y = div ? perspective_divide(acc[1], acc[3], sat) : scale_down(acc[1], sat);
        p.z = div ? perspective_divide(acc[2], acc[3], sat) : scale_down(acc[2], sat);
        p.div = div;
        p.sat = sat;
        return p;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        point_t e;
        if (!rst_n)
        begin
            matrix_rows[0] = ROW0_RESET;
            matrix_rows[1] = ROW1_RESET;
            matrix_rows[2] = ROW2_RESET;
            matrix_rows[3] = ROW3_RESET;
            w_threshold = WMIN_RESET;
            expected_points.delete();
            fail_count = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_points.size() == 0)
                begin
                    $error("result word with no expectation waiting");
                    fail_count++;
                end
                else
                begin
                    e = expected_points.pop_front();
                    if (out_x !== e.x)
                    begin
                        $error("out_x expected %0d actual %0d", e.x, out_x);
                        fail_count++;
                    end
                    if (out_y !== e.y)
                    begin
                        $error("out_y expected %0d actual %0d", e.y, out_y);
                        fail_count++;
                    end
                    if (out_z !== e.z)
                    begin
                        $error("out_z expected %0d actual %0d", e.z, out_z);
                        fail_count++;
                    end
                    if (divided !== e.div)
                    begin
                        $error("divided expected %0d actual %0d", e.div, divided);
                        fail_count++;
                    end
                    if (saturated !== e.sat)
                    begin
                        $error("saturated expected %0d actual %0d", e.sat, saturated);
                        fail_count++;
                    end
                end
            end
            if (in_valid && !in_stall)
                expected_points.push_back(transform_point(func, in_x, in_y, in_z));
            if (cfg_wen)
            begin
                if (cfg_index == REG_WMIN)
                    w_threshold = cfg_wdata[WMIN_WIDTH-1:0];
                else if (cfg_index <= REG_ROW3)
                    matrix_rows[cfg_index] = cfg_wdata;
            end
        end
    end

endmodule

// ----- bench/tb_homogeneous_point_transform_core.sv -----
// Testbench top: drives points and matrix settings into the transform core and gives the verdict.
module tb_homogeneous_point_transform_core;
    import hpt_pkg::*;

    localparam int DRAIN_CYCLES = 60;
    localparam int IDLE_LIMIT   = 5000;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_stall;
    logic                     func = 1'b0;
    logic signed [31:0]       in_x = '0;
    logic signed [31:0]       in_y = '0;
    logic signed [31:0]       in_z = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic signed [31:0]       out_x;
    logic signed [31:0]       out_y;
    logic signed [31:0]       out_z;
    logic                     divided;
    logic                     saturated;
    logic                     cfg_wen = 1'b0;
    logic [CFG_IDX_WIDTH-1:0] cfg_index = '0;
    logic [ROW_WIDTH-1:0]     cfg_wdata = '0;
    int                       fail_count;
    int                       pending;
    int                       quiet_cycles = 0;
    logic                     steady = 1'b0;

    always #5 clk = ~clk;

    homogeneous_point_transform_core dut (.*);

    hpt_checker checker_i (.*);

    always @(posedge clk)
    begin
        if (steady)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(99) < 34);
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > IDLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic logic [31:0] pick_coord();
        case ($urandom_range(5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $urandom_range(0, 32'h7_FFFF) - 32'h4_0000;
            3: return $urandom_range(0, 32'h7FF_FFFF) - 32'h400_0000;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [15:0] pick_coef();
        case ($urandom_range(5))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'h0100;
            3: return 16'h0000;
            4: return 16'($urandom_range(0, 16'h03FF) - 16'h0200);
            default: return 16'($urandom());
        endcase
    endfunction

    task automatic send_word(input logic f, input logic [31:0] x, input logic [31:0] y,
                             input logic [31:0] z);
        while (!steady && $urandom_range(99) < 34)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        func <= f;
        in_x <= x;
        in_y <= y;
        in_z <= z;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_WIDTH-1:0] idx, input logic [63:0] data);
        cfg_wen <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        cfg_wen <= 1'b0;
        @(posedge clk);
    endtask

    task automatic load_matrix(input int mode);
        logic [63:0] row;
        for (int r = 0; r < 4; r++)
        begin
            for (int c = 0; c < 4; c++)
                row[16*c +: 16] = (mode == 1) ? 16'h7FFF : (mode == 2) ? 16'h8000 : pick_coef();
            write_reg(r[CFG_IDX_WIDTH-1:0], row);
        end
        case ($urandom_range(3))
            0: write_reg(REG_WMIN, 64'hFFFF);
            1: write_reg(REG_WMIN, 64'h0);
            default: write_reg(REG_WMIN, {$urandom(), $urandom()});
        endcase
    endtask

    initial
    begin
        logic [31:0] ext [4];
        ext[0] = 32'h7FFF_FFFF;
        ext[1] = 32'h8000_0000;
        ext[2] = 32'h0;
        ext[3] = 32'hFFFF_FFFF;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int i = 0; i < 4; i++)
        begin
            send_word(1'b0, ext[i], ext[(i + 1) % 4], ext[(i + 2) % 4]);
            send_word(1'b1, ext[i], ext[(i + 3) % 4], ext[i]);
        end
        send_word(1'b0, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000);
        drain();
        write_reg(REG_ROW3, 64'h0);
        write_reg(REG_WMIN, 64'h0);
        send_word(1'b0, 32'h0001_0000, 32'h0, 32'h0);
        drain();
        write_reg(REG_ROW3, 64'h0000_0000_0000_0001);
        write_reg(REG_WMIN, 64'hFFFF);
        send_word(1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1);
        drain();
        write_reg(REG_ROW3, 64'h0001_0000_0000_0000);
        write_reg(REG_WMIN, 64'h0);
        send_word(1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
        send_word(1'b0, 32'h1234_5678, 32'h8765_4321, 32'h1);
        drain();
        for (int phase = 0; phase < 14; phase++)
        begin
            load_matrix(phase == 1 ? 1 : phase == 2 ? 2 : 0);
            steady <= (phase == 5);
            for (int i = 0; i < 100; i++)
                send_word($urandom_range(99) < 25, pick_coord(), pick_coord(), pick_coord());
            drain();
        end
        steady <= 1'b0;
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
